[src/sphere_of_influence_edge_filter_macros.svh]
// assertion macros used by the checker file
`ifndef SPHERE_OF_INFLUENCE_EDGE_FILTER_MACROS_SVH
`define SPHERE_OF_INFLUENCE_EDGE_FILTER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define SOIEF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define SOIEF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/sofi_pkg.sv]
// shared types and constants of the sphere-of-influence edge filter
`default_nettype none

package sofi_pkg;

  // fixed port widths
  localparam int unsigned VERTEX_W    = 10;
  localparam int unsigned WEIGHT_IN_W = 32;
  localparam int unsigned CMD_W       = 2;

  // parameter defaults
  localparam int unsigned NUM_VERTICES_DEF = 1024;
  localparam int unsigned WEIGHT_BITS_DEF  = 32;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD     = 2'd0,
    CMD_CLASSIFY = 2'd1,
    CMD_CLEAR    = 2'd2
  } cmd_e;

  // classify request from the sequencer to the result stage
  typedef struct packed {
    logic                valid;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;
  } cls_req_t;

endpackage

`default_nettype wire

[src/sofi_ram.sv]
// generic ram: one write port, two registered read ports
`default_nettype none

module sofi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr0_i,
  input  wire logic [AW-1:0]    raddr1_i,
  output logic      [WIDTH-1:0] rdata0_o,
  output logic      [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read ports, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

`default_nettype wire

[src/sofi_classify.sv]
// keep decision and output register of the edge filter
`default_nettype none

module sofi_classify import sofi_pkg::*; #(
  parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cls_req_t               req_i,
  input  wire logic [WEIGHT_BITS-1:0] weight_i,
  input  wire logic [WEIGHT_BITS:0]   word_a_i,
  input  wire logic [WEIGHT_BITS:0]   word_b_i,
  input  wire logic                   out_stall_i,
  output logic                        busy_o,
  output logic                        out_valid_o,
  output logic      [VERTEX_W-1:0]    out_vertex_a_o,
  output logic      [VERTEX_W-1:0]    out_vertex_b_o,
  output logic                        keep_o
);

  logic                 set_a, set_b;
  logic [WEIGHT_BITS:0] dist_sum;
  logic                 keep_d;
  logic                 out_valid_q;

  // unset distance is infinity, otherwise compare the widened sum
  assign set_a    = word_a_i[WEIGHT_BITS];
  assign set_b    = word_b_i[WEIGHT_BITS];
  assign dist_sum = {1'b0, word_a_i[WEIGHT_BITS-1:0]} + {1'b0, word_b_i[WEIGHT_BITS-1:0]};
  assign keep_d   = !set_a || !set_b || (dist_sum >= {1'b0, weight_i});

  // a held beat blocks the next result
  assign busy_o      = out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req_i.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      out_vertex_a_o <= req_i.vertex_a;
      out_vertex_b_o <= req_i.vertex_b;
      keep_o         <= keep_d;
    end
  end

endmodule

`default_nettype wire

[src/sphere_of_influence_edge_filter.sv]
// Sphere-of-influence edge filter, top level.
// Input channel (in_valid_i / in_stall_o) takes one command beat: load edge,
// classify edge or clear distance table. Output channel (out_valid_o /
// out_stall_i) gives one beat per classified ascending in-range edge.
// Distances live in one RAM word per vertex: a set flag and the nearest
// distance. The RAM has a single write port and registered read ports.
// A load passes IDLE, EXEC (first endpoint written) and WRB (second
// endpoint written); a classify passes IDLE and EXEC; an ignored edge or
// unused command stays in IDLE; a clear goes on to SWEEP over every vertex.
// These steps come from the registered read and from the single write port.
// in_stall_o is high outside IDLE. A classify result is registered in the
// output stage of sofi_classify when EXEC hands it over.
// Reset starts the same clearing sweep, which marks every distance unset;
// in_stall_o stays high during it.
// When the receiver stalls, the result beat holds; input beats keep being
// taken until a classify, which waits in its evaluate cycle until the output frees.
`default_nettype none

module sphere_of_influence_edge_filter import sofi_pkg::*; #(
  parameter int unsigned NUM_VERTICES = NUM_VERTICES_DEF,
  parameter int unsigned WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [CMD_W-1:0]       cmd_i,
  input  wire logic [VERTEX_W-1:0]    vertex_a_i,
  input  wire logic [VERTEX_W-1:0]    vertex_b_i,
  input  wire logic [WEIGHT_IN_W-1:0] edge_weight_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic      [VERTEX_W-1:0]    out_vertex_a_o,
  output logic      [VERTEX_W-1:0]    out_vertex_b_o,
  output logic                        keep_o
);

  localparam int unsigned AW     = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int unsigned WORD_W = WEIGHT_BITS + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_WRB   = 2'd2;
  localparam logic [1:0] ST_SWEEP = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [AW-1:0]          sweep_cnt_q, sweep_cnt_d;
  logic [VERTEX_W-1:0]    vertex_a_q, vertex_b_q;
  logic [WEIGHT_BITS-1:0] weight_q;
  logic                   is_load_q;

  logic                   accept;
  logic                   usable;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [WORD_W-1:0]      ram_wdata;
  logic [WORD_W-1:0]      word_a, word_b;
  logic                   upd_a, upd_b;
  logic                   cls_busy;
  cls_req_t               cls_req;

  // input handshake
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign usable     = (32'(vertex_a_i) < NUM_VERTICES) && (32'(vertex_b_i) < NUM_VERTICES) &&
                      (vertex_b_i > vertex_a_i);

  // running minimum update conditions
  assign upd_a = !word_a[WEIGHT_BITS] || (weight_q < word_a[WEIGHT_BITS-1:0]);
  assign upd_b = !word_b[WEIGHT_BITS] || (weight_q < word_b[WEIGHT_BITS-1:0]);

  // sequencer
  always_comb begin
    state_d          = state_q;
    sweep_cnt_d      = sweep_cnt_q;
    ram_we           = 1'b0;
    ram_waddr        = AW'(vertex_a_q);
    ram_wdata        = {1'b1, weight_q};
    cls_req.valid    = 1'b0;
    cls_req.vertex_a = vertex_a_q;
    cls_req.vertex_b = vertex_b_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            CMD_LOAD, CMD_CLASSIFY: begin
              if (usable) begin
                state_d = ST_EXEC;
              end
            end
            CMD_CLEAR: begin
              state_d     = ST_SWEEP;
              sweep_cnt_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_EXEC: begin
        if (is_load_q) begin
          ram_we  = upd_a;
          state_d = ST_WRB;
        end else if (!cls_busy) begin
          cls_req.valid = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_WRB: begin
        ram_we    = upd_b;
        ram_waddr = AW'(vertex_b_q);
        state_d   = ST_IDLE;
      end
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_cnt_q;
        ram_wdata = '0;
        if (sweep_cnt_q == AW'(NUM_VERTICES - 1)) begin
          state_d = ST_IDLE;
        end else begin
          sweep_cnt_d = sweep_cnt_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers, reset starts the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_cnt_q <= '0;
    end else begin
      state_q     <= state_d;
      sweep_cnt_q <= sweep_cnt_d;
    end
  end

  // captured edge
  always_ff @(posedge clk_i) begin
    if (accept) begin
      vertex_a_q <= vertex_a_i;
      vertex_b_q <= vertex_b_i;
      weight_q   <= WEIGHT_BITS'(edge_weight_i);
      is_load_q  <= (cmd_i == CMD_LOAD);
    end
  end

  // distance table: set flag over nearest distance
  sofi_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_VERTICES)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .re_i     (accept),
    .raddr0_i (AW'(vertex_a_i)),
    .raddr1_i (AW'(vertex_b_i)),
    .rdata0_o (word_a),
    .rdata1_o (word_b)
  );

  // keep decision and output beat
  sofi_classify #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_classify (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (cls_req),
    .weight_i       (weight_q),
    .word_a_i       (word_a),
    .word_b_i       (word_b),
    .out_stall_i    (out_stall_i),
    .busy_o         (cls_busy),
    .out_valid_o    (out_valid_o),
    .out_vertex_a_o (out_vertex_a_o),
    .out_vertex_b_o (out_vertex_b_o),
    .keep_o         (keep_o)
  );

endmodule

`default_nettype wire

[src/sofi_checker.sv]
// port-level checker of the edge filter and its bind
`default_nettype none

`include "sphere_of_influence_edge_filter_macros.svh"

module sofi_checker import sofi_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_stall_o,
  input wire logic [CMD_W-1:0]       cmd_i,
  input wire logic [VERTEX_W-1:0]    vertex_a_i,
  input wire logic [VERTEX_W-1:0]    vertex_b_i,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire logic [VERTEX_W-1:0]    out_vertex_a_o,
  input wire logic [VERTEX_W-1:0]    out_vertex_b_o,
  input wire logic                   keep_o
);

  logic                  in_beat;
  logic                  cls_beat;
  logic                  clr_beat;
  logic                  out_held;
  logic                  out_asc;
  logic [2*VERTEX_W:0]   out_beat;
  logic [2*VERTEX_W:0]   out_tag;
  logic [2*VERTEX_W:0]   cls_tag;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign cls_beat = in_beat && (cmd_i == CMD_CLASSIFY);
  assign clr_beat = in_beat && (cmd_i == CMD_CLEAR);
  assign out_held = out_valid_o && out_stall_i;
  assign out_asc  = out_vertex_b_o > out_vertex_a_o;
  assign out_beat = {out_vertex_a_o, out_vertex_b_o, keep_o};
  assign out_tag  = {1'b1, out_vertex_a_o, out_vertex_b_o};
  assign cls_tag  = {cls_beat, vertex_a_i, vertex_b_i};

  // stalled result beat holds
  `SOIEF_ASSERT_NEXT(a_out_hold, out_held, out_valid_o && $stable(out_beat), "stalled beat changed")

  // only ascending edges are classified
  `SOIEF_ASSERT_NOW(a_out_ascending, out_valid_o, out_asc, "result edge not ascending")

  // a fresh result must carry the edge of an earlier classify beat
  `SOIEF_ASSERT_NOW(a_out_from_cls, $rose(out_valid_o), out_tag == $past(cls_tag, 2), "orphan result")

  // a clear starts the sweep, which blocks input
  `SOIEF_ASSERT_NEXT(a_clear_stalls, clr_beat, in_stall_o, "clear did not stall input")

endmodule

bind sphere_of_influence_edge_filter sofi_checker u_sofi_checker (.*);

`default_nettype wire

[test/tb_sphere_of_influence_edge_filter.sv]
`timescale 1ns / 100ps
// testbench for the sphere-of-influence edge filter: distance-table scoreboard, random pacing
module tb_sphere_of_influence_edge_filter;
  import sofi_pkg::*;

  // command value the block leaves unused
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned ITEM_GOAL = 1150;
  // margin for the registered result path and one beat held under a stall
  localparam int unsigned SETTLE_CYCLES = 12;

  // tracks nearest distances and holds the verdicts still owed by the block
  class edge_filter_scoreboard;
    typedef struct {
      logic [VERTEX_W-1:0] vertex_a;
      logic [VERTEX_W-1:0] vertex_b;
      logic                keep;
    } edge_verdict_t;

    logic [WEIGHT_IN_W-1:0] nearest[NUM_VERTICES_DEF];
    bit                     has_dist[NUM_VERTICES_DEF];
    edge_verdict_t          verdicts[$];
    int unsigned            errors;

    function new();
      foreach (has_dist[i]) has_dist[i] = 1'b0;
      errors = 0;
    endfunction

    // running minimum of one endpoint
    function void lower_nearest(logic [VERTEX_W-1:0] v, logic [WEIGHT_IN_W-1:0] w);
      if (!has_dist[v] || w < nearest[v]) begin
        nearest[v]  = w;
        has_dist[v] = 1'b1;
      end
    endfunction

    // fold one accepted input beat into the table, queue a verdict for a classify
    function void note_beat(logic [CMD_W-1:0] cmd, logic [VERTEX_W-1:0] a,
                            logic [VERTEX_W-1:0] b, logic [WEIGHT_IN_W-1:0] w);
      edge_verdict_t        v;
      logic [WEIGHT_IN_W:0] dist_sum;
      if (cmd == CMD_CLEAR) begin
        foreach (has_dist[i]) has_dist[i] = 1'b0;
        return;
      end
      if (cmd == CMD_UNUSED || b <= a || a >= NUM_VERTICES_DEF || b >= NUM_VERTICES_DEF)
        return;
      if (cmd == CMD_LOAD) begin
        lower_nearest(a, w);
        lower_nearest(b, w);
        return;
      end
      v.vertex_a = a;
      v.vertex_b = b;
      // an unset distance is infinite, so the edge survives
      if (!has_dist[a] || !has_dist[b]) begin
        v.keep = 1'b1;
      end else begin
        dist_sum = {1'b0, nearest[a]} + {1'b0, nearest[b]};
        v.keep   = (dist_sum >= {1'b0, w});
      end
      verdicts.push_back(v);
    endfunction

    // compare one result beat with the oldest verdict
    function void check_result(logic [VERTEX_W-1:0] a, logic [VERTEX_W-1:0] b, logic keep);
      edge_verdict_t exp_v;
      if (verdicts.size() == 0) begin
        $error("unexpected result beat: out_vertex_a=%0d out_vertex_b=%0d keep=%0b",
               a, b, keep);
        errors++;
        return;
      end
      exp_v = verdicts.pop_front();
      if (a !== exp_v.vertex_a) begin
        $error("out_vertex_a mismatch: expected %0d, actual %0d", exp_v.vertex_a, a);
        errors++;
      end
      if (b !== exp_v.vertex_b) begin
        $error("out_vertex_b mismatch: expected %0d, actual %0d", exp_v.vertex_b, b);
        errors++;
      end
      if (keep !== exp_v.keep) begin
        $error("keep mismatch: expected %0b, actual %0b", exp_v.keep, keep);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [CMD_W-1:0]       cmd_i;
  logic [VERTEX_W-1:0]    vertex_a_i;
  logic [VERTEX_W-1:0]    vertex_b_i;
  logic [WEIGHT_IN_W-1:0] edge_weight_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [VERTEX_W-1:0]    out_vertex_a_o;
  logic [VERTEX_W-1:0]    out_vertex_b_o;
  logic                   keep_o;

  edge_filter_scoreboard sb;
  int unsigned           items_sent = 0;
  int unsigned           burst_left = 0;
  int unsigned           stall_left = 0;
  int unsigned           stall_mode = 0;

  sphere_of_influence_edge_filter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .vertex_a_i     (vertex_a_i),
    .vertex_b_i     (vertex_b_i),
    .edge_weight_i  (edge_weight_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_vertex_a_o (out_vertex_a_o),
    .out_vertex_b_o (out_vertex_b_o),
    .keep_o         (keep_o)
  );

  always #6 clk_i = ~clk_i;

  // receiver stall pattern: clear runs, random runs and solid stalls
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = (stall_mode == 2) ? $urandom_range(1, 12) : $urandom_range(1, 40);
    end
    stall_left--;
    case (stall_mode)
      0: begin
        out_stall_i = 1'b0;
      end
      1: begin
        out_stall_i = 1'($urandom_range(0, 1));
      end
      default: begin
        out_stall_i = 1'b1;
      end
    endcase
  end

  // result beats
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(out_vertex_a_o, out_vertex_b_o, keep_o);
  end

  // weight generator: full range, small, near the top, mid
  function automatic logic [WEIGHT_IN_W-1:0] pick_weight(int unsigned mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 1000);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
      default: return $urandom_range(0, 1 << 20);
    endcase
  endfunction

  // drive one beat, wait for it to be taken, then apply the sender's pacing
  task automatic send_beat(logic [CMD_W-1:0] cmd, logic [VERTEX_W-1:0] a,
                           logic [VERTEX_W-1:0] b, logic [WEIGHT_IN_W-1:0] w);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i    = 1'b1;
    cmd_i         = cmd;
    vertex_a_i    = a;
    vertex_b_i    = b;
    edge_weight_i = w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_beat(cmd, a, b, w);
    items_sent++;
    // bursts of random length, with the odd long stretch and no gap
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      @(negedge clk_i);
      in_valid_i    = 1'b0;
      cmd_i         = CMD_W'($urandom);
      vertex_a_i    = VERTEX_W'($urandom);
      vertex_b_i    = VERTEX_W'($urandom);
      edge_weight_i = $urandom;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
    end
  endtask

  // hold the sender until every verdict has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // run limit
  initial begin
    #6_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [VERTEX_W-1:0]    ea[16];
    logic [VERTEX_W-1:0]    eb[16];
    logic [WEIGHT_IN_W-1:0] ew[16];
    logic [VERTEX_W-1:0]    tmp;
    logic [WEIGHT_IN_W-1:0] w;
    int unsigned            base;
    int unsigned            span;
    int unsigned            n_edges;
    int unsigned            wmode;
    int unsigned            pick;

    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cmd_i         = CMD_LOAD;
    vertex_a_i    = '0;
    vertex_b_i    = '0;
    edge_weight_i = '0;
    out_stall_i   = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: unset distances, extremes, ignored edges, boundaries, clear
    send_beat(CMD_CLASSIFY, 10'd1, 10'd2, 32'd5);
    send_beat(CMD_LOAD, 10'd0, 10'd1023, 32'hFFFF_FFFF);
    send_beat(CMD_LOAD, 10'd5, 10'd5, 32'd1);
    send_beat(CMD_LOAD, 10'd7, 10'd3, 32'd1);
    send_beat(CMD_UNUSED, 10'd10, 10'd20, 32'd0);
    send_beat(CMD_CLASSIFY, 10'd0, 10'd1023, 32'hFFFF_FFFF);
    send_beat(CMD_LOAD, 10'd0, 10'd1, 32'd0);
    send_beat(CMD_CLASSIFY, 10'd0, 10'd1023, 32'hFFFF_FFFF);
    send_beat(CMD_CLASSIFY, 10'd0, 10'd1, 32'd1);
    send_beat(CMD_CLASSIFY, 10'd0, 10'd1, 32'd0);
    send_beat(CMD_LOAD, 10'd2, 10'd3, 32'd100);
    send_beat(CMD_LOAD, 10'd3, 10'd4, 32'd50);
    send_beat(CMD_CLASSIFY, 10'd2, 10'd3, 32'd150);
    send_beat(CMD_CLASSIFY, 10'd2, 10'd3, 32'd151);
    send_beat(CMD_CLASSIFY, 10'd2, 10'd9, 32'd5);
    send_beat(CMD_CLASSIFY, 10'd3, 10'd3, 32'd0);
    send_beat(CMD_CLASSIFY, 10'd4, 10'd2, 32'd0);
    send_beat(CMD_LOAD, 10'd2, 10'd3, 32'd200);
    send_beat(CMD_CLASSIFY, 10'd2, 10'd4, 32'd150);
    wait_drained();
    send_beat(CMD_CLEAR, 10'd1023, 10'd0, 32'hFFFF_FFFF);
    send_beat(CMD_CLASSIFY, 10'd2, 10'd3, 32'd151);
    send_beat(CMD_LOAD, 10'd2, 10'd3, 32'hFFFF_FFFF);
    send_beat(CMD_CLASSIFY, 10'd2, 10'd3, 32'hFFFF_FFFF);

    // random: mostly load-then-classify passes over small graphs, some noise
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 9) < 7)
          send_beat(CMD_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom), $urandom);
        span    = $urandom_range(3, 40);
        base    = $urandom_range(0, 1023 - span);
        n_edges = $urandom_range(4, 16);
        wmode   = $urandom_range(0, 3);
        for (int i = 0; i < n_edges; i++) begin
          ea[i] = VERTEX_W'(base + $urandom_range(0, span - 1));
          eb[i] = VERTEX_W'($urandom_range(ea[i] + 1, base + span));
          ew[i] = pick_weight(wmode);
          // a few broken edges
          pick = $urandom_range(0, 19);
          if (pick == 0) begin
            tmp   = ea[i];
            ea[i] = eb[i];
            eb[i] = tmp;
          end else if (pick == 1) begin
            eb[i] = ea[i];
          end
        end
        // load pass
        for (int i = 0; i < n_edges; i++) begin
          if ($urandom_range(0, 19) == 0)
            send_beat(CMD_UNUSED, VERTEX_W'($urandom), VERTEX_W'($urandom), $urandom);
          send_beat(CMD_LOAD, ea[i], eb[i], ew[i]);
        end
        if ($urandom_range(0, 9) == 0)
          wait_drained();
        // classify pass, weights nudged around the boundary
        for (int i = 0; i < n_edges; i++) begin
          case ($urandom_range(0, 3))
            0: w = ew[i];
            1: w = ew[i] + 1;
            2: w = ew[i] - 1;
            default: w = pick_weight(wmode);
          endcase
          send_beat(CMD_CLASSIFY, ea[i], eb[i], w);
        end
        // edges that may touch vertices never loaded
        repeat ($urandom_range(1, 3)) begin
          tmp = VERTEX_W'(base + $urandom_range(0, span - 1));
          send_beat(CMD_CLASSIFY, tmp, VERTEX_W'($urandom_range(tmp + 1, 1023)),
                    pick_weight(wmode));
        end
      end else begin
        repeat ($urandom_range(5, 15)) begin
          pick = $urandom_range(0, 2);
          send_beat((pick == 0) ? CMD_LOAD : (pick == 1) ? CMD_CLASSIFY : CMD_UNUSED,
                    VERTEX_W'($urandom), VERTEX_W'($urandom), $urandom);
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
